/* rtl/btff_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Boundary tag first-fit allocator package
// Transaction types and status codes shared by the allocator files.
// ----------------------------------------------------------------------------
package btff_pkg;

   localparam int unsigned TAG_BYTES = 8;

   localparam logic       KIND_ALLOC = 1'b0;
   localparam logic       KIND_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [16:0] request_size;
      logic [15:0] payload_offset_in;
   } req_type;

   typedef struct packed {
      logic [15:0] payload_offset;
      logic [1:0]  status;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/boundary_tag_first_fit_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Boundary tag first-fit allocator
// Heap manager for a byte arena: allocate walks block headers first-fit and
// splits, free validates the header and merges with free neighbors.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction is taken at a rising edge where start is high and
// busy is low. req_data.kind selects allocate or free. Each request produces
// exactly one response transaction: rsp_strobe is high for one cycle with
// rsp_data holding the payload offset and status. The receiver cannot stall,
// so the response is simply presented for that single cycle.
// Sequence: the walk reads headers one at a time, each in an address state
// and then a check state, through a single registered read port. A failed
// allocate or a rejected free is answered from the check state. An allocate
// writes the block header and, after a split, the remainder header. A free
// reads the header of a following block, if there is one, and then writes
// the merged header. A free whose offset is below the tag size is answered
// without leaving idle. Busy is high until the strobe cycle, so the next
// request can follow then.
// Reset: after reset the block writes the header of the single free block
// that spans the arena, with busy high, then goes idle.
// Only headers at block starts are kept; trailers are never consulted.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator #(
   parameter int unsigned HEAP_BYTES = 65536
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  btff_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output btff_pkg::rsp_type  rsp_data
);

   // Address width into the arena, and offset width able to hold sums past
   // the arena end.
   localparam int unsigned AW = $clog2(HEAP_BYTES);
   localparam int unsigned OW = AW + 2;
   localparam int unsigned XW = (OW > 18) ? OW : 18;

   localparam logic [OW-1:0] HEAP_W  = OW'(HEAP_BYTES);
   localparam logic [OW-1:0] TAG_W   = OW'(btff_pkg::TAG_BYTES);
   localparam logic [OW-1:0] TAG2_W  = OW'(2 * btff_pkg::TAG_BYTES);
   localparam logic [AW-1:0] INIT_SZ = AW'(HEAP_BYTES - 2 * btff_pkg::TAG_BYTES);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_A_RD,
      ST_A_CHK,
      ST_A_WR,
      ST_A_WR2,
      ST_F_RD,
      ST_F_CHK,
      ST_F_NRD,
      ST_F_NCHK,
      ST_F_WR
   } state_type;

   state_type       state_ff;
   logic [16:0]     req_size_ff;
   logic [15:0]     h_ff;
   logic [OW-1:0]   walk_ff;
   logic [OW-1:0]   prev_ff;
   logic [OW-1:0]   nxt_ff;
   logic [AW-1:0]   psize_ff;
   logic            palloc_ff;
   logic            has_prev_ff;
   logic [AW-1:0]   hsize_ff;
   logic [AW-1:0]   bsize_ff;
   logic [AW-1:0]   nsize_ff;
   logic            nmerge_ff;
   logic            split_ff;
   logic            rsp_strobe_ff;
   btff_pkg::rsp_type rsp_ff;

   // Header memory: one entry per byte offset, {allocated, payload size}.
   // Only entries at block starts on the chain are ever read.
   logic [AW:0]     hdr_mem [HEAP_BYTES];
   logic [AW:0]     rd_ff;
   logic [AW-1:0]   rd_addr;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [AW:0]     wr_data;

   logic [AW-1:0]   rd_size;
   logic            rd_alloc;
   logic [OW-1:0]   next_blk;
   logic [OW-1:0]   merge_sum;

   assign rd_size  = rd_ff[AW-1:0];
   assign rd_alloc = rd_ff[AW];
   // Start of the block after the one just read.
   assign next_blk = walk_ff + OW'(rd_size) + TAG2_W;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      rd_addr = (state_ff == ST_F_NRD) ? nxt_ff[AW-1:0] : walk_ff[AW-1:0];
   end

   // Merged payload size for a free: the freed block, optionally the free
   // previous block in front of it and the free next block behind it.
   always_comb begin
      merge_sum = OW'(hsize_ff);
      if (has_prev_ff && !palloc_ff) begin
         merge_sum = merge_sum + OW'(psize_ff) + TAG2_W;
      end
      if (nmerge_ff) begin
         merge_sum = merge_sum + OW'(nsize_ff) + TAG2_W;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = walk_ff[AW-1:0];
      wr_data = {1'b0, INIT_SZ};
      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {1'b0, INIT_SZ};
         end
         ST_A_WR: begin
            wr_en   = 1'b1;
            wr_addr = walk_ff[AW-1:0];
            wr_data = {1'b1, split_ff ? AW'(req_size_ff) : bsize_ff};
         end
         ST_A_WR2: begin
            // Remainder block behind the split.
            wr_en   = 1'b1;
            wr_addr = AW'(walk_ff + OW'(req_size_ff) + TAG2_W);
            wr_data = {1'b0, AW'(bsize_ff - AW'(req_size_ff) - AW'(TAG2_W))};
         end
         ST_F_WR: begin
            wr_en   = 1'b1;
            wr_addr = (has_prev_ff && !palloc_ff) ? prev_ff[AW-1:0] : AW'(h_ff);
            wr_data = {1'b0, merge_sum[AW-1:0]};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem[wr_addr] <= wr_data;
      end
      rd_ff <= hdr_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         rsp_strobe_ff <= 1'b0;
         has_prev_ff   <= 1'b0;
         nmerge_ff     <= 1'b0;
         split_ff      <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_INIT: begin
               state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (start) begin
                  req_size_ff <= req_data.request_size;
                  walk_ff     <= '0;
                  has_prev_ff <= 1'b0;
                  nmerge_ff   <= 1'b0;
                  if (req_data.kind == btff_pkg::KIND_ALLOC) begin
                     state_ff <= ST_A_RD;
                  end else if (req_data.payload_offset_in <
                               16'(btff_pkg::TAG_BYTES)) begin
                     rsp_ff.payload_offset <= '0;
                     rsp_ff.status         <= btff_pkg::STATUS_BAD_FREE;
                     rsp_strobe_ff         <= 1'b1;
                  end else begin
                     h_ff     <= req_data.payload_offset_in -
                                 16'(btff_pkg::TAG_BYTES);
                     state_ff <= ST_F_RD;
                  end
               end
            end
            ST_A_RD: begin
               state_ff <= ST_A_CHK;
            end
            ST_A_CHK: begin
               if (!rd_alloc && (XW'(rd_size) >= XW'(req_size_ff))) begin
                  bsize_ff <= rd_size;
                  split_ff <= (XW'(req_size_ff) + XW'(TAG2_W)) < XW'(rd_size);
                  state_ff <= ST_A_WR;
               end else if (next_blk >= HEAP_W) begin
                  rsp_ff.payload_offset <= '0;
                  rsp_ff.status         <= btff_pkg::STATUS_NO_FIT;
                  rsp_strobe_ff         <= 1'b1;
                  state_ff              <= ST_IDLE;
               end else begin
                  walk_ff  <= next_blk;
                  state_ff <= ST_A_RD;
               end
            end
            ST_A_WR: begin
               if (split_ff) begin
                  state_ff <= ST_A_WR2;
               end else begin
                  rsp_ff.payload_offset <= 16'(walk_ff + TAG_W);
                  rsp_ff.status         <= btff_pkg::STATUS_OK;
                  rsp_strobe_ff         <= 1'b1;
                  state_ff              <= ST_IDLE;
               end
            end
            ST_A_WR2: begin
               rsp_ff.payload_offset <= 16'(walk_ff + TAG_W);
               rsp_ff.status         <= btff_pkg::STATUS_OK;
               rsp_strobe_ff         <= 1'b1;
               state_ff              <= ST_IDLE;
            end
            ST_F_RD: begin
               state_ff <= ST_F_CHK;
            end
            ST_F_CHK: begin
               if (XW'(walk_ff) == XW'(h_ff)) begin
                  if (!rd_alloc) begin
                     // Double free or free of a free block.
                     rsp_ff.payload_offset <= '0;
                     rsp_ff.status         <= btff_pkg::STATUS_BAD_FREE;
                     rsp_strobe_ff         <= 1'b1;
                     state_ff              <= ST_IDLE;
                  end else begin
                     hsize_ff <= rd_size;
                     nxt_ff   <= next_blk;
                     if (next_blk >= HEAP_W) begin
                        state_ff <= ST_F_WR;
                     end else begin
                        state_ff <= ST_F_NRD;
                     end
                  end
               end else if ((XW'(walk_ff) > XW'(h_ff)) || (next_blk >= HEAP_W)) begin
                  // The header is not the start of any block on the chain.
                  rsp_ff.payload_offset <= '0;
                  rsp_ff.status         <= btff_pkg::STATUS_BAD_FREE;
                  rsp_strobe_ff         <= 1'b1;
                  state_ff              <= ST_IDLE;
               end else begin
                  prev_ff     <= walk_ff;
                  psize_ff    <= rd_size;
                  palloc_ff   <= rd_alloc;
                  has_prev_ff <= 1'b1;
                  walk_ff     <= next_blk;
                  state_ff    <= ST_F_RD;
               end
            end
            ST_F_NRD: begin
               state_ff <= ST_F_NCHK;
            end
            ST_F_NCHK: begin
               nsize_ff  <= rd_size;
               nmerge_ff <= !rd_alloc;
               state_ff  <= ST_F_WR;
            end
            ST_F_WR: begin
               rsp_ff.payload_offset <= '0;
               rsp_ff.status         <= btff_pkg::STATUS_OK;
               rsp_strobe_ff         <= 1'b1;
               state_ff              <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Boundary tag first-fit allocator testbench
// Drives allocate and free transactions through the command port. It keeps
// its own block-chain model of the heap to predict each response, and checks
// every response field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned HEAP = 65536;
   localparam int unsigned TWO_TAGS = 2 * btff_pkg::TAG_BYTES;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   btff_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   btff_pkg::rsp_type rsp_data;

   boundary_tag_first_fit_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #6 clock = ~clock;

   // Heap model. Only block starts on the current chain are ever looked up,
   // so headers left behind by a merge are simply stale entries.
   int unsigned heap_size[int unsigned];
   bit          heap_used[int unsigned];

   // Responses the heap model has predicted and the block has not yet sent.
   btff_pkg::rsp_type pending_rsp[$];
   // Payload offsets that are currently allocated, used to aim free requests.
   int unsigned live_blocks[$];
   int unsigned last_freed = 0;
   int          mismatches = 0;
   int          idle_pct = 0;

   function automatic int unsigned block_after(int unsigned a);
      int unsigned n;
      n = a + heap_size[a] + TWO_TAGS;
      return (n >= HEAP) ? HEAP : n;
   endfunction

   function automatic void heap_reset();
      heap_size.delete();
      heap_used.delete();
      heap_size[0] = HEAP - TWO_TAGS;
      heap_used[0] = 1'b0;
   endfunction

   // Computes the response of one request and updates the heap model.
   function automatic btff_pkg::rsp_type heap_apply(btff_pkg::req_type r);
      btff_pkg::rsp_type res;
      int unsigned a, h, prv, cur, nxt, sz;
      bit          found, has_prev;
      res = '0;
      a = 0;
      prv = 0;
      found = 1'b0;
      has_prev = 1'b0;
      if (r.kind == btff_pkg::KIND_ALLOC) begin
         while (a < HEAP && (heap_used[a] || heap_size[a] < r.request_size))
            a = block_after(a);
         if (a >= HEAP) begin
            res.status = btff_pkg::STATUS_NO_FIT;
         end else begin
            sz = heap_size[a];
            heap_used[a] = 1'b1;
            // Split only when the leftover piece still has a payload byte.
            if (r.request_size + TWO_TAGS < sz) begin
               heap_size[a] = r.request_size;
               heap_size[a + r.request_size + TWO_TAGS] = sz - r.request_size - TWO_TAGS;
               heap_used[a + r.request_size + TWO_TAGS] = 1'b0;
            end
            res.payload_offset = 16'(a + btff_pkg::TAG_BYTES);
            res.status = btff_pkg::STATUS_OK;
         end
         return res;
      end
      res.status = btff_pkg::STATUS_BAD_FREE;
      if (r.payload_offset_in < btff_pkg::TAG_BYTES) return res;
      h = r.payload_offset_in - btff_pkg::TAG_BYTES;
      while (a < HEAP) begin
         if (a == h) begin
            found = 1'b1;
            break;
         end
         if (a > h) break;
         prv = a;
         has_prev = 1'b1;
         a = block_after(a);
      end
      if (!found || !heap_used[h]) return res;
      heap_used[h] = 1'b0;
      nxt = block_after(h);
      cur = h;
      // The block at the arena start has no predecessor to merge into.
      if (has_prev && !heap_used[prv]) begin
         heap_size[prv] = heap_size[prv] + heap_size[h] + TWO_TAGS;
         cur = prv;
      end
      if (nxt < HEAP && !heap_used[nxt])
         heap_size[cur] = heap_size[cur] + heap_size[nxt] + TWO_TAGS;
      res.status = btff_pkg::STATUS_OK;
      return res;
   endfunction

   // Sends one transaction, predicts its response, then may leave a random gap.
   task automatic send_request(logic kind, int unsigned size, int unsigned offset);
      btff_pkg::rsp_type res;
      int      gap;
      int      idx;
      @(negedge clock);
      start <= 1'b1;
      req_data <= '{kind: kind, request_size: 17'(size), payload_offset_in: 16'(offset)};
      // Busy is stable between the falling and rising edges.
      #1;
      while (busy) @(negedge clock);
      @(posedge clock);
      res = heap_apply('{kind: kind, request_size: 17'(size),
                         payload_offset_in: 16'(offset)});
      pending_rsp.push_back(res);
      if (kind == btff_pkg::KIND_ALLOC && res.status == btff_pkg::STATUS_OK) begin
         live_blocks.push_back(res.payload_offset);
      end else if (kind == btff_pkg::KIND_FREE && res.status == btff_pkg::STATUS_OK) begin
         idx = -1;
         foreach (live_blocks[i]) if (live_blocks[i] == offset) idx = i;
         if (idx >= 0) live_blocks.delete(idx);
         last_freed = offset;
      end
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_all_responses();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Every response is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: offset %0d status %0d",
                        rsp_data.payload_offset, rsp_data.status);
         end else begin
            if (rsp_data.payload_offset !== pending_rsp[0].payload_offset ||
                rsp_data.status !== pending_rsp[0].status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response error: expected offset %0d status %0d, got %0d %0d",
                           pending_rsp[0].payload_offset, pending_rsp[0].status,
                           rsp_data.payload_offset, rsp_data.status);
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   // Whole-arena cases: exact fit, a remainder too small to split, oversize.
   task automatic test_whole_arena();
      send_request(btff_pkg::KIND_ALLOC, HEAP - TWO_TAGS, 16'hFFFF);
      send_request(btff_pkg::KIND_ALLOC, 0, 0);
      send_request(btff_pkg::KIND_FREE, 17'h1FFFF, btff_pkg::TAG_BYTES);
      send_request(btff_pkg::KIND_ALLOC, HEAP - TWO_TAGS + 1, 0);
      send_request(btff_pkg::KIND_ALLOC, HEAP, 0);
      send_request(btff_pkg::KIND_ALLOC, HEAP - 32, 0);
      send_request(btff_pkg::KIND_FREE, 0, btff_pkg::TAG_BYTES);
   endtask

   // Zero-byte blocks, first-block free, merges on both sides.
   task automatic test_split_merge();
      send_request(btff_pkg::KIND_ALLOC, 0, 0);
      send_request(btff_pkg::KIND_ALLOC, 100, 0);
      send_request(btff_pkg::KIND_ALLOC, 5, 0);
      send_request(btff_pkg::KIND_FREE, 0, 8);
      send_request(btff_pkg::KIND_FREE, 0, 140);
      send_request(btff_pkg::KIND_FREE, 0, 24);
      send_request(btff_pkg::KIND_ALLOC, 1, 0);
      send_request(btff_pkg::KIND_FREE, 0, 8);
   endtask

   // Invalid frees: below tag size, not a block start, double free, out of range.
   task automatic test_bad_free();
      send_request(btff_pkg::KIND_ALLOC, 40, 0);
      send_request(btff_pkg::KIND_FREE, 0, 0);
      send_request(btff_pkg::KIND_FREE, 0, 7);
      send_request(btff_pkg::KIND_FREE, 0, 9);
      send_request(btff_pkg::KIND_FREE, 0, 16'hFFFF);
      send_request(btff_pkg::KIND_FREE, 0, 8);
      send_request(btff_pkg::KIND_FREE, 0, 8);
   endtask

   // Random mix of allocates, with sizes kept mostly modest so the chain stays
   // short, and frees mostly of live blocks; the rest is noise and double frees.
   task automatic test_random(int count, int pct);
      int unsigned sel, size, offset;
      idle_pct = pct;
      repeat (count) begin
         sel = $urandom_range(0, 99);
         if (sel < ((live_blocks.size() > 25) ? 25 : 55)) begin
            sel = $urandom_range(0, 99);
            if (sel < 75)      size = $urandom_range(0, 600);
            else if (sel < 88) size = $urandom_range(0, 16);
            else if (sel < 94) size = $urandom_range(0, 20000);
            else if (sel < 97) size = HEAP;
            else               size = $urandom_range(0, 17'h1FFFF);
            send_request(btff_pkg::KIND_ALLOC, size, $urandom_range(0, 65535));
         end else begin
            sel = $urandom_range(0, 99);
            if (sel < 75 && live_blocks.size() > 0)
               offset = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            else if (sel < 85) offset = last_freed;
            else if (sel < 90) offset = $urandom_range(0, 7);
            else               offset = $urandom_range(0, 65535);
            send_request(btff_pkg::KIND_FREE, $urandom_range(0, 17'h1FFFF), offset);
         end
      end
   endtask

   initial begin
      heap_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_whole_arena();
      test_split_merge();
      test_bad_free();
      test_random(300, 0);
      test_random(300, 62);
      // Let the block drain completely before carrying on.
      @(negedge clock);
      start <= 1'b0;
      wait_all_responses();
      test_random(300, 32);
      test_random(300, 0);
      @(negedge clock);
      start <= 1'b0;
      wait_all_responses();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("boundary_tag_first_fit_allocator: match");
      end else begin
         $display("boundary_tag_first_fit_allocator: mismatch");
      end
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #200000000;
      $display("boundary_tag_first_fit_allocator: mismatch");
      $finish;
   end

endmodule

/* sim.f */
rtl/btff_pkg.sv
rtl/boundary_tag_first_fit_allocator.sv
sim/testbench.sv
